FILE: rtl/jhs_pkg.sv
`default_nettype none

package jhs_pkg;

    // marker bytes
    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_SOS    = 8'hDA;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_RST0   = 8'hD0;
    localparam logic [7:0] MK_RST7   = 8'hD7;
    localparam logic [7:0] MK_TEM    = 8'h01;
    localparam logic [7:0] MK_ZERO   = 8'h00;

    // result status codes
    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_NO_SOF0 = 2'd1;
    localparam logic [1:0] ST_NO_SOI  = 2'd2;

    // SOF0 body offsets of the size fields
    localparam logic [2:0] OFS_HEIGHT_HI = 3'd1;
    localparam logic [2:0] OFS_HEIGHT_LO = 3'd2;
    localparam logic [2:0] OFS_WIDTH_HI  = 3'd3;
    localparam logic [2:0] OFS_WIDTH_LO  = 3'd4;
    localparam logic [2:0] OFS_MAX       = 3'd7;

    // one input word as held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    // one result word
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] image_height;
        logic [15:0] image_width;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/jpeg_header_size_scanner.sv
// JPEG header size scanner.
// Input channel: one file byte per word (i_data_byte) with i_last_byte set
// on the final byte, handshaked by i_in_valid / o_in_ready. Output channel:
// one result word (o_status, o_image_height, o_image_width) handshaked by
// o_out_valid / i_out_ready. Status 0 means a size was found in an SOF0
// segment, 1 means SOS or end of file came without SOF0, 2 means the file
// does not begin with FF D8. At most one result per file: at SOS, at a bad
// start, or with the last byte; later bytes up to the last are dropped.
// Throughput is one byte per cycle while no stalled result blocks the input:
// every byte goes through an input register and a combinational parse step
// that also loads the result register.
// When the receiver stalls, the result register holds its word; the input
// register still accepts bytes that produce no result, and backpressure
// reaches o_in_ready only when a byte with a result meets a full result
// register. Reset (synchronous, active low) empties both registers and puts
// the parser back to expecting the first SOI byte; the last byte of a file
// does the same for the parse state.
`default_nettype none

module jpeg_header_size_scanner (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_last_byte,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_image_height,
    output logic [15:0] o_image_width
);

    jhs_pkg::t_in_word in_word;
    jhs_pkg::t_in_word held_word;
    jhs_pkg::t_result  result;
    logic              held_valid;
    logic              take;

    assign in_word.data_byte = i_data_byte;
    assign in_word.last_byte = i_last_byte;

    // input register
    jhs_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_word     (in_word),
        .o_valid    (held_valid),
        .i_take     (take),
        .o_word     (held_word)
    );

    // parse step and result register
    jhs_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (held_valid),
        .i_word      (held_word),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_status       = result.status;
    assign o_image_height = result.image_height;
    assign o_image_width  = result.image_width;

endmodule

`default_nettype wire

FILE: rtl/jhs_in_reg.sv
`default_nettype none

module jhs_in_reg (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  jhs_pkg::t_in_word i_word,
    output logic             o_valid,
    input  wire              i_take,
    output jhs_pkg::t_in_word o_word
);

    logic             r_valid;
    jhs_pkg::t_in_word r_word;

    // free when empty or when the held word is consumed this cycle
    assign o_in_ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_word     = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_word <= i_word;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/jhs_parser.sv
`default_nettype none

module jhs_parser (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  jhs_pkg::t_in_word i_word,
    output logic             o_take,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output jhs_pkg::t_result o_result
);

    typedef enum logic [2:0] {
        PH_SOI0,
        PH_SOI1,
        PH_SCAN,
        PH_MARK,
        PH_LENH,
        PH_LENL,
        PH_BODY,
        PH_DONE
    } t_phase;

    t_phase          r_phase,     n_phase;
    logic [15:0]     r_remaining, n_remaining;
    logic [2:0]      r_offset,    n_offset;
    logic            r_in_sof0,   n_in_sof0;
    logic [15:0]     r_height,    n_height;
    logic [15:0]     r_width,     n_width;
    logic            r_size_found, n_size_found;
    logic            r_out_valid;
    jhs_pkg::t_result r_result;

    logic        emit;
    logic [1:0]  emit_status;
    logic [7:0]  b;
    logic [15:0] seg_len;
    logic [15:0] rem_dec;
    logic        standalone;

    // a word is consumed once the result register can take its outcome;
    // a word without a result never waits
    assign o_take      = i_valid && (!emit || !r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    assign b          = i_word.data_byte;
    assign seg_len    = {r_remaining[15:8], b};
    assign rem_dec    = r_remaining - 16'd1;
    assign standalone = (b == jhs_pkg::MK_ZERO) || (b == jhs_pkg::MK_TEM) ||
                        ((b >= jhs_pkg::MK_RST0) && (b <= jhs_pkg::MK_RST7));

    // per-byte parse step
    always_comb begin
        n_phase      = r_phase;
        n_remaining  = r_remaining;
        n_offset     = r_offset;
        n_in_sof0    = r_in_sof0;
        n_height     = r_height;
        n_width      = r_width;
        n_size_found = r_size_found;
        emit         = 1'b0;
        emit_status  = jhs_pkg::ST_FOUND;

        case (r_phase)
            PH_SOI0: begin
                if (b == jhs_pkg::MK_PREFIX) begin
                    n_phase = PH_SOI1;
                end else begin
                    emit        = 1'b1;
                    emit_status = jhs_pkg::ST_NO_SOI;
                end
            end
            PH_SOI1: begin
                if (b == jhs_pkg::MK_SOI) begin
                    n_phase = PH_SCAN;
                end else begin
                    emit        = 1'b1;
                    emit_status = jhs_pkg::ST_NO_SOI;
                end
            end
            PH_SCAN: begin
                if (b == jhs_pkg::MK_PREFIX) n_phase = PH_MARK;
            end
            PH_MARK: begin
                if (b == jhs_pkg::MK_PREFIX) begin
                    // fill byte, stay
                end else if (b == jhs_pkg::MK_SOS) begin
                    emit        = 1'b1;
                    emit_status = r_size_found ? jhs_pkg::ST_FOUND : jhs_pkg::ST_NO_SOF0;
                end else if (standalone) begin
                    n_phase = PH_SCAN;
                end else begin
                    n_in_sof0 = (b == jhs_pkg::MK_SOF0);
                    n_phase   = PH_LENH;
                end
            end
            PH_LENH: begin
                n_remaining = {b, 8'h00};
                n_phase     = PH_LENL;
            end
            PH_LENL: begin
                n_remaining = (seg_len >= 16'd2) ? (seg_len - 16'd2) : 16'd0;
                n_offset    = '0;
                if (r_in_sof0) begin
                    n_size_found = 1'b1;
                    n_height     = '0;
                    n_width      = '0;
                end
                if (seg_len <= 16'd2) begin
                    n_in_sof0 = 1'b0;
                    n_phase   = PH_SCAN;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (r_in_sof0) begin
                    case (r_offset)
                        jhs_pkg::OFS_HEIGHT_HI: n_height[15:8] = b;
                        jhs_pkg::OFS_HEIGHT_LO: n_height[7:0]  = b;
                        jhs_pkg::OFS_WIDTH_HI:  n_width[15:8]  = b;
                        jhs_pkg::OFS_WIDTH_LO:  n_width[7:0]   = b;
                        default: ;
                    endcase
                end
                if (r_offset < jhs_pkg::OFS_MAX) n_offset = r_offset + 3'd1;
                n_remaining = rem_dec;
                if (rem_dec == 16'd0) begin
                    n_in_sof0 = 1'b0;
                    n_phase   = PH_SCAN;
                end
            end
            default: begin
                // result already given: drop bytes until the last one
            end
        endcase

        if (emit) n_phase = PH_DONE;

        // end of stream closes the file if nothing was reported yet
        if (i_word.last_byte && !emit && (n_phase != PH_DONE)) begin
            emit = 1'b1;
            if ((n_phase == PH_SOI0) || (n_phase == PH_SOI1)) begin
                emit_status = jhs_pkg::ST_NO_SOI;
            end else begin
                emit_status = n_size_found ? jhs_pkg::ST_FOUND : jhs_pkg::ST_NO_SOF0;
            end
        end
    end

    // parse state, back to reset values after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SOI0;
            r_remaining  <= '0;
            r_offset     <= '0;
            r_in_sof0    <= 1'b0;
            r_height     <= '0;
            r_width      <= '0;
            r_size_found <= 1'b0;
        end else if (o_take) begin
            if (i_word.last_byte) begin
                r_phase      <= PH_SOI0;
                r_remaining  <= '0;
                r_offset     <= '0;
                r_in_sof0    <= 1'b0;
                r_height     <= '0;
                r_width      <= '0;
                r_size_found <= 1'b0;
            end else begin
                r_phase      <= n_phase;
                r_remaining  <= n_remaining;
                r_offset     <= n_offset;
                r_in_sof0    <= n_in_sof0;
                r_height     <= n_height;
                r_width      <= n_width;
                r_size_found <= n_size_found;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && emit) begin
            r_result.status       <= emit_status;
            r_result.image_height <= n_height;
            r_result.image_width  <= n_width;
        end
    end

`ifndef NO_ASSERTIONS
    // the last byte always leaves the parser waiting for a fresh SOI
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && i_word.last_byte |=> (r_phase == PH_SOI0) && !r_size_found)
        else $error("parser state not cleared after last byte");

    // before SOI no size can have been captured
    a_pre_soi_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_SOI0) || (r_phase == PH_SOI1)) |->
            (r_height == 16'd0) && (r_width == 16'd0) && !r_size_found)
        else $error("size state set before SOI");

    // a segment body is only entered with bytes left to skip
    a_body_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_remaining != 16'd0))
        else $error("segment body with nothing remaining");

    // missing SOI reports zero size
    a_no_soi_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_result.status == jhs_pkg::ST_NO_SOI) |->
            (r_result.image_height == 16'd0) && (r_result.image_width == 16'd0))
        else $error("nonzero size with missing SOI");

    // a new result is loaded only into a free or draining result register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && emit |-> !r_out_valid || i_out_ready)
        else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

FILE: sim/tb.sv
`default_nettype none

module tb;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_LIMIT  = 5000;
    localparam logic [7:0]  MK_APP0      = 8'hE0;

    // parse phases of the byte scanner
    typedef enum logic [3:0] {
        SC_SOI_FF, SC_SOI_D8, SC_HUNT, SC_MARKER,
        SC_LEN_HI, SC_LEN_LO, SC_BODY, SC_DONE
    } t_scan_phase;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;
    logic [15:0] o_image_height;
    logic [15:0] o_image_width;

    jpeg_header_size_scanner u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_image_height (o_image_height),
        .o_image_width  (o_image_width)
    );

    // scanner state mirrored on the testbench side
    t_scan_phase scan_phase;
    logic [15:0] seg_left;
    logic [2:0]  seg_pos;
    logic        sof0_active;
    logic [15:0] cap_height;
    logic [15:0] cap_width;
    logic        sof0_seen;
    logic        file_reported;

    jhs_pkg::t_result size_reports[$];
    jhs_pkg::t_result want;
    logic [7:0]  file_bytes[$];

    int          fail_count = 0;
    int          items_sent = 0;
    int          cycles     = 0;
    bit          idle_on    = 1'b1;
    bit          hold_req   = 1'b0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run length guard
    initial begin : watchdog
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic clear_scan_state();
        scan_phase    = SC_SOI_FF;
        seg_left      = '0;
        seg_pos       = '0;
        sof0_active   = 1'b0;
        cap_height    = '0;
        cap_width     = '0;
        sof0_seen     = 1'b0;
        file_reported = 1'b0;
    endtask

    task automatic post_report(input logic [1:0] status);
        jhs_pkg::t_result r;
        r.status       = status;
        r.image_height = cap_height;
        r.image_width  = cap_width;
        size_reports.push_back(r);
        file_reported = 1'b1;
        scan_phase    = SC_DONE;
    endtask

    function automatic bit is_standalone(input logic [7:0] code);
        return code == jhs_pkg::MK_ZERO || code == jhs_pkg::MK_TEM ||
               (code >= jhs_pkg::MK_RST0 && code <= jhs_pkg::MK_RST7);
    endfunction

    // advance the mirrored scanner by one accepted byte
    task automatic scan_byte(input logic [7:0] b, input logic last);
        logic [15:0] len;
        case (scan_phase)
            SC_SOI_FF: begin
                if (b == jhs_pkg::MK_PREFIX) scan_phase = SC_SOI_D8;
                else post_report(jhs_pkg::ST_NO_SOI);
            end
            SC_SOI_D8: begin
                if (b == jhs_pkg::MK_SOI) scan_phase = SC_HUNT;
                else post_report(jhs_pkg::ST_NO_SOI);
            end
            SC_HUNT: begin
                if (b == jhs_pkg::MK_PREFIX) scan_phase = SC_MARKER;
            end
            SC_MARKER: begin
                if (b == jhs_pkg::MK_PREFIX) begin
                    // fill byte, stay
                end else if (b == jhs_pkg::MK_SOS) begin
                    post_report(sof0_seen ? jhs_pkg::ST_FOUND : jhs_pkg::ST_NO_SOF0);
                end else if (is_standalone(b)) begin
                    scan_phase = SC_HUNT;
                end else begin
                    sof0_active = (b == jhs_pkg::MK_SOF0);
                    scan_phase  = SC_LEN_HI;
                end
            end
            SC_LEN_HI: begin
                seg_left   = {b, 8'h00};
                scan_phase = SC_LEN_LO;
            end
            SC_LEN_LO: begin
                len      = seg_left | {8'h00, b};
                seg_left = (len >= 16'd2) ? len - 16'd2 : 16'd0;
                seg_pos  = '0;
                if (sof0_active) begin
                    sof0_seen  = 1'b1;
                    cap_height = '0;
                    cap_width  = '0;
                end
                if (seg_left == 16'd0) begin
                    sof0_active = 1'b0;
                    scan_phase  = SC_HUNT;
                end else begin
                    scan_phase = SC_BODY;
                end
            end
            SC_BODY: begin
                if (sof0_active) begin
                    case (seg_pos)
                        jhs_pkg::OFS_HEIGHT_HI: cap_height[15:8] = b;
                        jhs_pkg::OFS_HEIGHT_LO: cap_height[7:0]  = b;
                        jhs_pkg::OFS_WIDTH_HI:  cap_width[15:8]  = b;
                        jhs_pkg::OFS_WIDTH_LO:  cap_width[7:0]   = b;
                        default: ;
                    endcase
                end
                if (seg_pos < jhs_pkg::OFS_MAX) seg_pos = seg_pos + 3'd1;
                seg_left = seg_left - 16'd1;
                if (seg_left == 16'd0) begin
                    sof0_active = 1'b0;
                    scan_phase  = SC_HUNT;
                end
            end
            default: ;
        endcase

        // end of file: report if nothing was reported, then start over
        if (last) begin
            if (!file_reported) begin
                if (scan_phase == SC_SOI_FF || scan_phase == SC_SOI_D8)
                    post_report(jhs_pkg::ST_NO_SOI);
                else
                    post_report(sof0_seen ? jhs_pkg::ST_FOUND : jhs_pkg::ST_NO_SOF0);
            end
            clear_scan_state();
        end
    endtask

    // offer one word; valid stays up after acceptance until the next call
    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_data_byte = b;
        i_last_byte = last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        scan_byte(b, last);
        items_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            push_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    // receiver: random stalls per word, long hold on request
    initial begin : receiver
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = idle_on ? $urandom_range(0, 8) : 0;
            end
            repeat (stall) begin
                @(negedge i_clk);
                i_out_ready = 1'b0;
            end
            @(negedge i_clk);
            i_out_ready = 1'b1;
            @(posedge i_clk);
            while (!o_out_valid && !hold_req) @(posedge i_clk);
        end
    end

    // compare every accepted result word with the oldest pending report
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (size_reports.size() == 0) begin
                $error("unexpected result word: status %0d height %0d width %0d",
                       o_status, o_image_height, o_image_width);
                fail_count++;
            end else begin
                want = size_reports.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_image_height !== want.image_height) begin
                    $error("image_height: expected %0d, got %0d",
                           want.image_height, o_image_height);
                    fail_count++;
                end
                if (o_image_width !== want.image_width) begin
                    $error("image_width: expected %0d, got %0d",
                           want.image_width, o_image_width);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_segment_code();
        logic [7:0] c;
        do c = 8'($urandom);
        while (is_standalone(c) || c == jhs_pkg::MK_SOS || c == jhs_pkg::MK_PREFIX ||
               c == jhs_pkg::MK_SOF0);
        return c;
    endfunction

    function automatic logic [15:0] pick_length(input int max_len);
        if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 1));
        return 16'($urandom_range(2, max_len));
    endfunction

    task automatic add_segment(input logic [7:0] code, input logic [15:0] len_field);
        int body;
        file_bytes.push_back(jhs_pkg::MK_PREFIX);
        if ($urandom_range(0, 4) == 0) file_bytes.push_back(jhs_pkg::MK_PREFIX);
        file_bytes.push_back(code);
        file_bytes.push_back(len_field[15:8]);
        file_bytes.push_back(len_field[7:0]);
        body = (len_field >= 16'd2) ? int'(len_field) - 2 : 0;
        repeat (body) file_bytes.push_back(pick_byte());
    endtask

    // well-formed file with random segments, or a short run of noise
    task automatic build_random_file();
        logic [15:0] long_len;
        int          nseg;
        file_bytes.delete();
        if ($urandom_range(0, 99) < 85) begin
            file_bytes.push_back(jhs_pkg::MK_PREFIX);
            file_bytes.push_back(jhs_pkg::MK_SOI);
            nseg = $urandom_range(0, 4);
            repeat (nseg) begin
                case ($urandom_range(0, 7))
                    0, 1: add_segment(jhs_pkg::MK_SOF0, pick_length(17));
                    2: begin
                        file_bytes.push_back(jhs_pkg::MK_PREFIX);
                        case ($urandom_range(0, 2))
                            0:       file_bytes.push_back(jhs_pkg::MK_ZERO);
                            1:       file_bytes.push_back(jhs_pkg::MK_TEM);
                            default: file_bytes.push_back(
                                         8'(jhs_pkg::MK_RST0 + $urandom_range(0, 7)));
                        endcase
                    end
                    3: repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom));
                    default: add_segment(pick_segment_code(), pick_length(12));
                endcase
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    file_bytes.push_back(jhs_pkg::MK_PREFIX);
                    file_bytes.push_back(jhs_pkg::MK_SOS);
                    repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom));
                end
                5: begin
                    // long segment cut off by the end of the file
                    long_len = 16'($urandom);
                    file_bytes.push_back(jhs_pkg::MK_PREFIX);
                    file_bytes.push_back($urandom_range(0, 1) ? jhs_pkg::MK_SOF0
                                                              : pick_segment_code());
                    file_bytes.push_back(long_len[15:8]);
                    file_bytes.push_back(long_len[7:0]);
                    repeat ($urandom_range(0, 3)) file_bytes.push_back(pick_byte());
                end
                default: ;
            endcase
        end else begin
            file_bytes.push_back($urandom_range(0, 1) ? jhs_pkg::MK_PREFIX : pick_byte());
            file_bytes.push_back($urandom_range(0, 1) ? jhs_pkg::MK_SOI : pick_byte());
            repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom));
            if ($urandom_range(0, 1)) file_bytes.delete(file_bytes.size() - 1);
        end
    endtask

    // bad starts, end before SOI, fill bytes, standalone and short segments
    task automatic test_directed();
        file_bytes = {jhs_pkg::MK_ZERO, jhs_pkg::MK_PREFIX};
        send_file();
        file_bytes = {jhs_pkg::MK_PREFIX, jhs_pkg::MK_ZERO};
        send_file();
        file_bytes = {jhs_pkg::MK_PREFIX};
        send_file();
        file_bytes = {jhs_pkg::MK_PREFIX, jhs_pkg::MK_SOI, jhs_pkg::MK_ZERO};
        send_file();
        file_bytes = {jhs_pkg::MK_PREFIX, jhs_pkg::MK_SOI,
                      jhs_pkg::MK_PREFIX, jhs_pkg::MK_PREFIX, jhs_pkg::MK_RST0,
                      jhs_pkg::MK_PREFIX, jhs_pkg::MK_TEM,
                      jhs_pkg::MK_PREFIX, jhs_pkg::MK_ZERO,
                      jhs_pkg::MK_PREFIX, MK_APP0, 8'h00, 8'h01,
                      jhs_pkg::MK_PREFIX, jhs_pkg::MK_SOF0, 8'h00, 8'h04, 8'h00, 8'hFF,
                      jhs_pkg::MK_PREFIX, jhs_pkg::MK_SOS};
        send_file();
    endtask

    // receiver holds off while one-byte bad files keep coming
    task automatic test_backpressure();
        logic [7:0] b;
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (12) begin
            do b = 8'($urandom);
            while (b == jhs_pkg::MK_PREFIX);
            file_bytes = {b};
            send_file();
        end
        idle_on = 1'b1;
    endtask

    task automatic test_random();
        while (items_sent < 600) begin
            idle_on = ($urandom_range(0, 3) != 0);
            build_random_file();
            send_file();
        end
        idle_on = 1'b1;
    endtask

    initial begin : main
        int spin;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        clear_scan_state();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_random();

        // drain
        @(negedge i_clk);
        i_in_valid = 1'b0;
        spin = 0;
        while (size_reports.size() != 0 && spin < DRAIN_LIMIT) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (8) @(posedge i_clk);
        if (size_reports.size() != 0) begin
            $error("%0d result words never arrived", size_reports.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
